@@ sv/edb_pkg.sv @@
package edb_pkg;

   localparam int MAX_STEPS = 48;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int TERM_W    = 36;
   localparam int SUM_W     = TERM_W + 2;
   localparam int LANES     = 3;

   typedef struct packed {
      logic signed [31:0] scaled_pos_x;
      logic signed [31:0] scaled_pos_y;
      logic signed [31:0] scaled_pos_z;
      logic [31:0]        axis_sq_x;
      logic [31:0]        axis_sq_y;
      logic [31:0]        axis_sq_z;
   } req_data_type;

   typedef struct packed {
      logic [31:0] root_value;
      logic        status;
   } rsp_data_type;

   typedef struct packed {
      logic              busy;
      logic [TERM_W-1:0] term;
   } lane_status_type;

   typedef logic [LANES-1:0][31:0] mag_vec_type;

endpackage

@@ sv/edb_isqrt.sv @@
module edb_isqrt import edb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  mag_vec_type mag,
   output logic        busy,
   output logic [31:0] root
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ACC  = 2'd2;
   localparam logic [1:0] S_ROOT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      prod_in  = prod_ff;
      val_in   = val_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in   = 2'd0;
               val_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = 64'(mag[idx_ff]) * 64'(mag[idx_ff]);
            state_in = S_ACC;
         end
         S_ACC: begin
            val_in = val_ff + prod_ff;
            if (idx_ff == 2'(LANES - 1)) begin
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               state_in = S_ROOT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_ROOT: begin
            if (val_ff >= trial) begin
               val_in = val_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      val_ff  <= val_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign root = res_ff[31:0];

endmodule

@@ sv/edb_lane.sv @@
module edb_lane import edb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [31:0]     mag,
   input  logic [32:0]     denom,
   output lane_status_type status
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_DIV  = 2'd1;
   localparam logic [1:0] L_MUL  = 2'd2;
   localparam logic [1:0] L_ADD  = 2'd3;
   localparam logic [33:0] RATIO_CAP = 34'd1 << 33;

   logic [1:0]        state_ff, state_in;
   logic [33:0]       rem_ff, rem_in;
   logic [33:0]       quo_ff, quo_in;
   logic [5:0]        k_ff, k_in;
   logic [31:0]       mag_ff, mag_in;
   logic [32:0]       den_ff, den_in;
   logic [63:0]       prod_ff, prod_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic              nbit;
   logic [33:0]       shifted;
   logic [34:0]       diff;
   logic [33:0]       quo_next;
   logic [1:0]        hi;
   logic [3:0]        hisq;
   logic [33:0]       hilo;

   always_comb begin
      nbit     = (k_ff == 6'd33) ? mag_ff[1] : ((k_ff == 6'd32) ? mag_ff[0] : 1'b0);
      shifted  = {rem_ff[32:0], nbit};
      diff     = {1'b0, shifted} - {2'b0, den_ff};
      quo_next = {quo_ff[32:0], ~diff[34]};
      hi       = quo_ff[33:32];
      hisq     = 4'(hi) * 4'(hi);
      hilo     = 34'(hi) * 34'(quo_ff[31:0]);
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      k_in     = k_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      term_in  = term_ff;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               mag_in = mag;
               den_in = denom;
               if (mag == '0) begin
                  term_in = '0;
               end else if ({3'b0, mag} >= {denom, 2'b00}) begin
                  // quotient reaches 2^34 or more: saturate
                  term_in = TERM_W'(1) << 34;
               end else begin
                  rem_in   = {4'b0, mag[31:2]};
                  quo_in   = '0;
                  k_in     = 6'd33;
                  state_in = L_DIV;
               end
            end
         end
         L_DIV: begin
            if (!diff[34]) rem_in = diff[33:0];
            else           rem_in = shifted;
            quo_in = quo_next;
            k_in   = k_ff - 6'd1;
            if (k_ff == 6'd0) begin
               if (quo_next > RATIO_CAP) quo_in = RATIO_CAP;
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            prod_in  = 64'(quo_ff[31:0]) * 64'(quo_ff[31:0]);
            state_in = L_ADD;
         end
         L_ADD: begin
            term_in  = {hisq, 32'b0} + {1'b0, hilo, 1'b0} + {4'b0, prod_ff[63:32]};
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      k_ff    <= k_in;
      mag_ff  <= mag_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
   end

   assign status.busy = (state_ff != L_IDLE);
   assign status.term = term_ff;

endmodule

@@ sv/ellipsoid_distance_bisection_core.sv @@
// Point-to-ellipsoid distance root finder. Each transfer on req_ carries three
// scaled coordinates and three squared semi-axes; the core bisects
// f(t) = sum (p_i/(t+q_i))^2 - 1 on [0, sqrt(sum p_i^2)] and returns the final
// midpoint, or an end point where f is exactly zero, with status 0, or status 1
// and root 0 when there is no sign change. Three lanes evaluate the axis terms
// side by side, each with a one-bit-per-cycle divider plus a square and add. A
// query runs the square root, two end-point evaluations and up to MAX_STEPS (48)
// midpoint evaluations. One query is in flight at a time; the next is taken
// while the previous result still waits on rsp_. The user must write stop_width
// on csr_ only while idle; the core itself does not enforce this.
module ellipsoid_distance_bisection_core import edb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROOT   = 3'd1;
   localparam logic [2:0] ST_LAUNCH = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam logic [1:0] PH_LO  = 2'd0;
   localparam logic [1:0] PH_HI  = 2'd1;
   localparam logic [1:0] PH_MID = 2'd2;

   localparam logic [SUM_W-1:0] ONE_Q32 = SUM_W'(1) << 32;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [15:0]       stop_width_ff;
   mag_vec_type       mag_ff, mag_in;
   mag_vec_type       q_ff, q_in;
   logic [31:0]       lo_ff, lo_in, hi_ff, hi_in, t_ff, t_in;
   logic              flo_pos_ff, flo_pos_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [31:0]       result_ff, result_in;
   logic              stat_ff, stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              sq_busy;
   logic [31:0]       sq_root;
   logic              lane_start;
   lane_status_type   lane_st [LANES];
   logic              lanes_busy;
   logic [SUM_W-1:0]  fsum;
   logic              f_pos, f_zero;
   logic [31:0]       width, mid;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_width_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         stop_width_ff <= csr_wdata;
      end
   end

   edb_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .mag   (mag_in),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   assign lane_start = (state_ff == ST_LAUNCH);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      edb_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .mag    (mag_ff[i]),
         .denom  ({1'b0, t_ff} + {1'b0, q_ff[i]}),
         .status (lane_st[i])
      );
   end

   // merge the lane terms
   always_comb begin
      lanes_busy = 1'b0;
      fsum       = '0;
      for (int i = 0; i < LANES; i++) begin
         lanes_busy = lanes_busy | lane_st[i].busy;
         fsum       = fsum + SUM_W'(lane_st[i].term);
      end
      f_pos  = (fsum > ONE_Q32);
      f_zero = (fsum == ONE_Q32);
      width  = hi_ff - lo_ff;
      mid    = lo_ff + (width >> 1);
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      mag_in     = mag_ff;
      q_in       = q_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      t_in       = t_ff;
      flo_pos_in = flo_pos_ff;
      steps_in   = steps_ff;
      result_in  = result_ff;
      stat_in    = stat_ff;
      if (accept) begin
         mag_in[0] = mag32(req_data.scaled_pos_x);
         mag_in[1] = mag32(req_data.scaled_pos_y);
         mag_in[2] = mag32(req_data.scaled_pos_z);
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               q_in[0]  = req_data.axis_sq_x;
               q_in[1]  = req_data.axis_sq_y;
               q_in[2]  = req_data.axis_sq_z;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (!sq_busy) begin
               lo_in    = '0;
               hi_in    = sq_root;
               t_in     = '0;
               steps_in = '0;
               phase_in = PH_LO;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (!lanes_busy) begin
               case (phase_ff)
                  PH_LO: begin
                     if (f_zero) begin
                        result_in = '0;
                        stat_in   = 1'b0;
                        state_in  = ST_DONE;
                     end else begin
                        flo_pos_in = f_pos;
                        t_in       = hi_ff;
                        phase_in   = PH_HI;
                        state_in   = ST_LAUNCH;
                     end
                  end
                  PH_HI: begin
                     if (f_zero) begin
                        result_in = hi_ff;
                        stat_in   = 1'b0;
                        state_in  = ST_DONE;
                     end else if (f_pos == flo_pos_ff) begin
                        result_in = '0;
                        stat_in   = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        stat_in  = 1'b0;
                        state_in = ST_STEP;
                     end
                  end
                  default: begin
                     // collapse the bracket on an exact zero
                     if (f_zero) begin
                        lo_in    = t_ff;
                        hi_in    = t_ff;
                        state_in = ST_STEP;
                        steps_in = STEP_W'(MAX_STEPS);
                     end else begin
                        if (f_pos != flo_pos_ff) hi_in = t_ff;
                        else                     lo_in = t_ff;
                        steps_in = steps_ff + STEP_W'(1);
                        state_in = ST_STEP;
                     end
                  end
               endcase
            end
         end
         ST_STEP: begin
            if (steps_ff == STEP_W'(MAX_STEPS) || width <= 32'(stop_width_ff)
                || mid == lo_ff || mid == hi_ff) begin
               result_in = mid;
               state_in  = ST_DONE;
            end else begin
               t_in     = mid;
               phase_in = PH_MID;
               state_in = ST_LAUNCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.root_value = result_ff;
         rsp_data_in.status     = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff   <= phase_in;
      mag_ff     <= mag_in;
      q_ff       <= q_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      t_ff       <= t_in;
      flo_pos_ff <= flo_pos_in;
      steps_ff   <= steps_in;
      result_ff  <= result_in;
      stat_ff    <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.root_value == 32'd0)
      else $error("inside flag with nonzero root");

   a_bracket_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> lo_ff <= hi_ff)
      else $error("bracket inverted");

   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> steps_ff <= STEP_W'(MAX_STEPS))
      else $error("step count past cap");

   a_lane_launch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAUNCH |-> !lanes_busy)
      else $error("lane started while busy");

endmodule
